[hw/rtl/utf8l_pkg.sv]
package utf8l_pkg;

	// lead byte ranges
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	// continuation byte pattern
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_CODE = 8'h80;

	// second byte limits for the shortest-form, surrogate and range checks
	localparam logic [7:0] E0_MIN_SECOND = 8'hA0;
	localparam logic [7:0] ED_LEAD       = 8'hED;
	localparam logic [7:0] ED_MAX_SECOND = 8'h9F;
	localparam logic [7:0] F0_MIN_SECOND = 8'h90;
	localparam logic [7:0] F4_MAX_SECOND = 8'h8F;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int UNIT_COUNT_W    = 16;
	localparam int INC_W           = 3;

	// next state and code unit increment for one byte
	typedef struct packed {
		logic [7:0]       lead;
		logic [1:0]       held;
		logic [INC_W-1:0] inc;
	} step_t;

	// pending sequence state as seen by the step logic
	typedef struct packed {
		logic [7:0] lead;
		logic [1:0] held;
	} pend_t;

	// sequence length opened by a byte, 1 if it cannot lead
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd1;
		if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
		if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
		if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_CODE;
	endfunction

	// second byte check against the lead
	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic ok;
		ok = is_cont(b);
		if (lead == LEAD3_LO && b < E0_MIN_SECOND) ok = 1'b0;
		if (lead == ED_LEAD && b > ED_MAX_SECOND) ok = 1'b0;
		if (lead == LEAD4_LO && b < F0_MIN_SECOND) ok = 1'b0;
		if (lead == LEAD4_HI && b > F4_MAX_SECOND) ok = 1'b0;
		return ok;
	endfunction

endpackage

[hw/rtl/utf8l_step.sv]
module utf8l_step (
	input  utf8l_pkg::pend_t      pend,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output utf8l_pkg::step_t      step
);
	import utf8l_pkg::*;

	logic [2:0] byte_len;
	logic [2:0] lead_len;
	logic [2:0] held_ext;
	logic       ok;

	assign byte_len = seq_len(data_byte);
	assign lead_len = seq_len(pend.lead);
	assign held_ext = {1'b0, pend.held};

	// continuation check for the held sequence
	always_comb begin
		ok = 1'b0;
		if (lead_len > held_ext) begin
			if (pend.held == 2'd1) begin
				ok = second_ok(pend.lead, data_byte);
			end else begin
				ok = is_cont(data_byte);
			end
		end
	end

	// next pending state and units added by this byte
	always_comb begin
		step.lead = pend.lead;
		step.held = pend.held;
		step.inc  = '0;
		if (pend.held == 2'd0) begin
			if (byte_len == 3'd1) begin
				step.inc = 3'd1;
			end else begin
				step.lead = data_byte;
				step.held = 2'd1;
			end
		end else if (ok) begin
			if (held_ext + 3'd1 == lead_len) begin
				step.inc  = (lead_len == 3'd4) ? 3'd2 : 3'd1;
				step.lead = '0;
				step.held = '0;
			end else begin
				step.held = pend.held + 2'd1;
			end
		end else begin
			// broken sequence: held bytes count one each, then retry as lead
			if (byte_len == 3'd1) begin
				step.inc  = held_ext + 3'd1;
				step.lead = '0;
				step.held = '0;
			end else begin
				step.inc  = held_ext;
				step.lead = data_byte;
				step.held = 2'd1;
			end
		end
		// end of string: leftover bytes count one each
		if (last_byte) begin
			step.inc  = step.inc + {1'b0, step.held};
			step.lead = '0;
			step.held = '0;
		end
	end

endmodule

[hw/rtl/utf8l_acc.sv]
module utf8l_acc #(
	parameter int COUNT_WIDTH = utf8l_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   last_byte,
	input  utf8l_pkg::step_t       step,
	output utf8l_pkg::pend_t       pend,
	output logic [COUNT_WIDTH-1:0] total,
	output logic                   total_ovf
);
	import utf8l_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   ovf_q;
	logic [7:0]             lead_q;
	logic [1:0]             held_q;
	logic [COUNT_WIDTH:0]   sum;

	assign pend.lead = lead_q;
	assign pend.held = held_q;

	// saturating add, carry out means past the maximum
	assign sum       = {1'b0, count_q} + {{(COUNT_WIDTH + 1 - INC_W){1'b0}}, step.inc};
	assign total     = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
	assign total_ovf = ovf_q | sum[COUNT_WIDTH];

	// running state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			lead_q  <= '0;
			held_q  <= '0;
		end else if (en) begin
			lead_q <= step.lead;
			held_q <= step.held;
			if (last_byte) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= total;
				ovf_q   <= total_ovf;
			end
		end
	end

endmodule

[hw/rtl/utf8_utf16_length_counter_core.sv]
// UTF-8 to UTF-16 length counter.
// Input stream s_axis: one byte of a UTF-8 string per request, tlast on the
// final byte. Output stream m_axis: one request per string carrying the number
// of UTF-16 code units the string converts to, saturating at the counter
// width, plus a flag that saturation happened.
// Throughput: one byte per cycle while no last byte waits on a full output
// register, with the combinational decode and add in the accumulate stage. A last
// byte is taken into the input register, and its result is then loaded into the
// output register, which drives m_axis_tvalid.
// Invalid or truncated sequences count one unit per offending byte.
// Reset clears the pending sequence, the count and both registers; the next
// byte starts a new string. The output register holds a result until taken;
// while it is full and m_axis_tready is low, bytes that are not last still
// flow through, and a last byte waits in the input register, which then
// drops s_axis_tready.
module utf8_utf16_length_counter_core #(
	parameter int COUNT_WIDTH = utf8l_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [15:0] unit_count, [16] count_saturated
);
	import utf8l_pkg::*;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   adv_s1;
	logic                   out_valid_q;
	logic [UNIT_COUNT_W-1:0] count_q;
	logic                   sat_q;
	pend_t                  pend;
	step_t                  step;
	logic [COUNT_WIDTH-1:0] total;
	logic                   total_ovf;
	logic [COUNT_WIDTH+UNIT_COUNT_W-1:0] total_ext;

	// stage 1 moves unless it holds a last byte and the output is full and not taken
	assign adv_s1        = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// decode of one byte against the pending sequence
	utf8l_step u_step (
		.pend      (pend),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.step      (step)
	);

	// running count and pending sequence
	utf8l_acc #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv_s1),
		.last_byte (last_s1),
		.step      (step),
		.pend      (pend),
		.total     (total),
		.total_ovf (total_ovf)
	);

	assign total_ext = {{UNIT_COUNT_W{1'b0}}, total};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			count_q <= total_ext[UNIT_COUNT_W-1:0];
			sat_q   <= total_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, sat_q, count_q};

endmodule
